@@ rtl/tphc_pkg.sv @@
// ----------------------------------------------------------------------------
// tphc_pkg
// Shared types and constants of the temperature, pressure and humidity
// compensation datapath.
// ----------------------------------------------------------------------------
package tphc_pkg;

    // Number of quotient bits, one per divider stage.
    localparam int DIV_STEPS = 32;

    // Number of configuration registers and the address bits that select one.
    localparam int NUM_REGS  = 8;
    localparam int REG_AW    = 3;

    // Register indexes.
    localparam logic [REG_AW-1:0] REG_TEMP_COEFFS  = 3'd0;
    localparam logic [REG_AW-1:0] REG_PRESS_LOW    = 3'd1;
    localparam logic [REG_AW-1:0] REG_PRESS_HIGH   = 3'd2;
    localparam logic [REG_AW-1:0] REG_MIXED        = 3'd3;
    localparam logic [REG_AW-1:0] REG_HUM_OFFSET   = 3'd4;
    localparam logic [REG_AW-1:0] REG_TEMP_LIMITS  = 3'd5;
    localparam logic [REG_AW-1:0] REG_PRESS_LIMITS = 3'd6;
    localparam logic [REG_AW-1:0] REG_HUM_LIMITS   = 3'd7;

    // Humidity ceiling before the final shift, in Q10.22.
    localparam logic [31:0] HUM_CEIL = 32'd419430400;

    // Reciprocal of 1000: x / 1000 == (x * HUM_DIV_MAGIC) >> HUM_DIV_SHIFT
    // for every 32-bit unsigned x.
    localparam logic [28:0] HUM_DIV_MAGIC = 29'd274877907;
    localparam int          HUM_DIV_SHIFT = 38;

    // Data that rides alongside the pressure divider.
    typedef struct packed {
        logic [15:0] temp;
        logic [31:0] hum;
        logic        half;
        logic        zero;
    } t_side;

endpackage

@@ rtl/tphc_div.sv @@
// ----------------------------------------------------------------------------
// tphc_div
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tphc_div
    import tphc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  logic        i_valid,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_valid,
    output logic [31:0] o_quot
);

    logic [31:0]          r_rem [DIV_STEPS];
    logic [31:0]          r_nq  [DIV_STEPS];
    logic [31:0]          r_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_v;

    logic [31:0]          n_rem [DIV_STEPS];
    logic [31:0]          n_nq  [DIV_STEPS];
    logic [31:0]          n_den [DIV_STEPS];

    // One shift, compare and subtract per stage; quotient bits fill the
    // numerator register from the bottom as its bits are consumed.
    always_comb begin
        logic [31:0] rem_in;
        logic [31:0] nq_in;
        logic [31:0] den_in;
        logic [32:0] trial;
        logic        ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                rem_in = '0;
                nq_in  = i_num;
                den_in = i_den;
            end else begin
                rem_in = r_rem[k-1];
                nq_in  = r_nq[k-1];
                den_in = r_den[k-1];
            end
            trial    = {rem_in, nq_in[31]};
            ge       = (trial >= {1'b0, den_in});
            n_rem[k] = ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
            n_nq[k]  = {nq_in[30:0], ge};
            n_den[k] = den_in;
        end
    end

    // Valid bits travel with the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quot  = r_nq[DIV_STEPS-1];

endmodule

@@ rtl/tph_sensor_compensation_core.sv @@
// ----------------------------------------------------------------------------
// tph_sensor_compensation_core
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// The core accepts one raw sample set per clock while the output is not
// stalled and returns one compensated result set per sample, in order,
// through 16 stages of multiply and add, a 32-stage divider for pressure
// (one quotient bit per stage), three pressure correction stages and the
// output register. A stall on the output freezes the whole pipeline, so no
// transfer is lost or repeated. Coefficients and limits are written through
// the APB port at byte address 8 * index and should only change while the
// core is idle.
module tph_sensor_compensation_core
    import tphc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // Sample input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [19:0]        i_temp_raw,
    input  logic [19:0]        i_press_raw,
    input  logic [15:0]        i_hum_raw,
    // Result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_temperature,
    output logic [31:0]        o_pressure,
    output logic [31:0]        o_humidity
);

    localparam int PRE_STAGES  = 16;
    localparam int POST_STAGES = 3;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [63:0]       r_cfg [NUM_REGS];
    logic [REG_AW-1:0] w_idx;

    assign w_idx  = paddr[5:3];
    assign pready = 1'b1;
    assign prdata = r_cfg[w_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_TEMP_COEFFS: r_cfg[w_idx] <= {16'b0, pwdata[47:0]};
                REG_MIXED:       r_cfg[w_idx] <= {8'b0, pwdata[55:0]};
                REG_HUM_OFFSET,
                REG_TEMP_LIMITS: r_cfg[w_idx] <= {32'b0, pwdata[31:0]};
                default:         r_cfg[w_idx] <= pwdata;
            endcase
        end
    end

    // Coefficients as 32-bit two's complement words.
    logic signed [31:0] c_t1, c_t2, c_t3;
    logic signed [31:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
    logic signed [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;
    logic signed [31:0] c_tlo, c_thi;
    logic [31:0]        c_plo, c_phi, c_hlo, c_hhi;

    assign c_t1  = $signed({16'b0, r_cfg[REG_TEMP_COEFFS][47:32]});
    assign c_t2  = 32'(signed'(r_cfg[REG_TEMP_COEFFS][31:16]));
    assign c_t3  = 32'(signed'(r_cfg[REG_TEMP_COEFFS][15:0]));
    assign c_p1  = $signed({16'b0, r_cfg[REG_PRESS_LOW][63:48]});
    assign c_p2  = 32'(signed'(r_cfg[REG_PRESS_LOW][47:32]));
    assign c_p3  = 32'(signed'(r_cfg[REG_PRESS_LOW][31:16]));
    assign c_p4  = 32'(signed'(r_cfg[REG_PRESS_LOW][15:0]));
    assign c_p5  = 32'(signed'(r_cfg[REG_PRESS_HIGH][63:48]));
    assign c_p6  = 32'(signed'(r_cfg[REG_PRESS_HIGH][47:32]));
    assign c_p7  = 32'(signed'(r_cfg[REG_PRESS_HIGH][31:16]));
    assign c_p8  = 32'(signed'(r_cfg[REG_PRESS_HIGH][15:0]));
    assign c_p9  = 32'(signed'(r_cfg[REG_MIXED][55:40]));
    assign c_h1  = $signed({24'b0, r_cfg[REG_MIXED][39:32]});
    assign c_h2  = 32'(signed'(r_cfg[REG_MIXED][31:16]));
    assign c_h3  = $signed({24'b0, r_cfg[REG_MIXED][15:8]});
    assign c_h6  = 32'(signed'(r_cfg[REG_MIXED][7:0]));
    assign c_h4  = 32'(signed'(r_cfg[REG_HUM_OFFSET][31:16]));
    assign c_h5  = 32'(signed'(r_cfg[REG_HUM_OFFSET][15:0]));
    assign c_tlo = 32'(signed'(r_cfg[REG_TEMP_LIMITS][31:16]));
    assign c_thi = 32'(signed'(r_cfg[REG_TEMP_LIMITS][15:0]));
    assign c_plo = r_cfg[REG_PRESS_LIMITS][63:32];
    assign c_phi = r_cfg[REG_PRESS_LIMITS][31:0];
    assign c_hlo = r_cfg[REG_HUM_LIMITS][63:32];
    assign c_hhi = r_cfg[REG_HUM_LIMITS][31:0];

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a result waits stalled.
    // ------------------------------------------------------------------
    logic w_adv;
    logic r_out_valid;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_out_valid = r_out_valid;

    logic [PRE_STAGES-1:0]  r_vld;
    logic [POST_STAGES-1:0] r_pvld;
    logic                   w_div_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_pvld      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[PRE_STAGES-2:0], i_in_valid};
            r_pvld      <= {r_pvld[POST_STAGES-2:0], w_div_valid};
            r_out_valid <= r_pvld[POST_STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage registers ahead of the divider.
    // ------------------------------------------------------------------
    logic [19:0]        r1_traw, r1_praw, r2_praw, r3_praw, r4_praw, r5_praw;
    logic [19:0]        r6_praw, r7_praw, r8_praw, r9_praw;
    logic [15:0]        r1_hraw, r2_hraw, r3_hraw, r4_hraw, r5_hraw, r6_hraw, r7_hraw;
    logic signed [31:0] r2_a, r2_d, r3_m1, r3_dd, r4_v1, r4_m2, r5_tf;
    logic signed [31:0] r6_pv1, r6_hx;
    logic signed [31:0] r7_sq, r7_m5, r7_m2p, r7_hm5, r7_hv2m, r7_hv3m;
    logic signed [31:0] r8_v2a, r8_m3, r8_m5, r8_m2p, r8_v5h, r8_hv2, r8_hv3;
    logic signed [31:0] r9_v2, r9_v1, r9_hm, r9_v5h;
    logic signed [31:0] r10_pv1b, r10_pn, r10_hm2, r10_v5h;
    logic signed [31:0] r11_v1f, r11_p, r11_v3;
    logic signed [31:0] r12_rr, r12_v3, r13_m, r13_v3;
    logic [31:0]        r12_num, r13_num, r14_num, r15_num, r16_num;
    logic [31:0]        r12_den, r13_den, r14_den, r15_den, r16_den;
    logic               r12_half, r13_half, r14_half, r15_half, r16_half;
    logic               r12_zero, r13_zero, r14_zero, r15_zero, r16_zero;
    logic [15:0]        r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp;
    logic [15:0]        r12_temp, r13_temp, r14_temp, r15_temp, r16_temp;
    logic [31:0]        r14_hsel, r15_hsel, r16_hum;
    logic               r14_hbyp, r15_hbyp;
    logic [60:0]        r15_hprod;

    // Combinational helpers between stages.
    logic signed [31:0] w_t, w_r, w_hr, w_v5;
    logic [31:0]        w_v5c, w_h;
    logic [15:0]        w_tc;

    always_comb begin
        // Temperature in hundredths and its clamp.
        w_t = ((r5_tf * 32'sd5) + 32'sd128) >>> 8;
        if (w_t <= c_tlo) begin
            w_tc = c_tlo[15:0];
        end else if (c_thi <= w_t) begin
            w_tc = c_thi[15:0];
        end else begin
            w_tc = w_t[15:0];
        end
        w_r  = r6_pv1 >>> 2;
        w_hr = r11_v3 >>> 15;
        // Humidity bounded to its valid Q10.22 range.
        w_v5 = r13_v3 - (r13_m >>> 4);
        if (w_v5[31]) begin
            w_v5c = '0;
        end else if (w_v5 > HUM_CEIL) begin
            w_v5c = HUM_CEIL;
        end else begin
            w_v5c = w_v5;
        end
        w_h = w_v5c >> 12;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Input register.
            r1_traw <= i_temp_raw;
            r1_praw <= i_press_raw;
            r1_hraw <= i_hum_raw;
            // Temperature differences.
            r2_a    <= $signed({15'b0, r1_traw[19:3]}) - (c_t1 <<< 1);
            r2_d    <= $signed({16'b0, r1_traw[19:4]}) - c_t1;
            r2_praw <= r1_praw;
            r2_hraw <= r1_hraw;
            // First temperature products.
            r3_m1   <= r2_a * c_t2;
            r3_dd   <= r2_d * r2_d;
            r3_praw <= r2_praw;
            r3_hraw <= r2_hraw;
            r4_v1   <= r3_m1 >>> 11;
            r4_m2   <= (r3_dd >>> 12) * c_t3;
            r4_praw <= r3_praw;
            r4_hraw <= r3_hraw;
            // Fine temperature.
            r5_tf   <= r4_v1 + (r4_m2 >>> 14);
            r5_praw <= r4_praw;
            r5_hraw <= r4_hraw;
            // Clamped temperature; pressure and humidity offsets.
            r6_temp <= w_tc;
            r6_pv1  <= (r5_tf >>> 1) - 32'sd64000;
            r6_hx   <= r5_tf - 32'sd76800;
            r6_praw <= r5_praw;
            r6_hraw <= r5_hraw;
            // First pressure and humidity products.
            r7_sq   <= w_r * w_r;
            r7_m5   <= r6_pv1 * c_p5;
            r7_m2p  <= c_p2 * r6_pv1;
            r7_hm5  <= c_h5 * r6_hx;
            r7_hv2m <= r6_hx * c_h6;
            r7_hv3m <= r6_hx * c_h3;
            r7_temp <= r6_temp;
            r7_praw <= r6_praw;
            r7_hraw <= r6_hraw;
            // Second products and the humidity offset term.
            r8_v2a  <= (r7_sq >>> 11) * c_p6;
            r8_m3   <= c_p3 * (r7_sq >>> 13);
            r8_m5   <= r7_m5;
            r8_m2p  <= r7_m2p;
            r8_v5h  <= ($signed({2'b0, r7_hraw, 14'b0}) - (c_h4 <<< 20) - r7_hm5
                        + 32'sd16384) >>> 15;
            r8_hv2  <= r7_hv2m >>> 10;
            r8_hv3  <= r7_hv3m >>> 11;
            r8_temp <= r7_temp;
            r8_praw <= r7_praw;
            // Pressure sums.
            r9_v2   <= ((r8_v2a + (r8_m5 <<< 1)) >>> 2) + (c_p4 <<< 16);
            r9_v1   <= ((r8_m3 >>> 3) + (r8_m2p >>> 1)) >>> 18;
            r9_hm   <= r8_hv2 * (r8_hv3 + 32'sd32768);
            r9_v5h  <= r8_v5h;
            r9_temp <= r8_temp;
            r9_praw <= r8_praw;
            // Divisor product and dividend before scaling.
            r10_pv1b <= (32'sd32768 + r9_v1) * c_p1;
            r10_pn   <= (32'sd1048576 - $signed({12'b0, r9_praw})) - (r9_v2 >>> 12);
            r10_hm2  <= ((r9_hm >>> 10) + 32'sd2097152) * c_h2;
            r10_v5h  <= r9_v5h;
            r10_temp <= r9_temp;
            r11_v1f  <= r10_pv1b >>> 15;
            r11_p    <= r10_pn * 32'sd3125;
            r11_v3   <= r10_v5h * ((r10_hm2 + 32'sd8192) >>> 14);
            r11_temp <= r10_temp;
            // Divider operands: small dividends are doubled before division,
            // large ones have the quotient doubled afterwards.
            r12_num  <= r11_p[31] ? r11_p : {r11_p[30:0], 1'b0};
            r12_den  <= r11_v1f;
            r12_half <= r11_p[31];
            r12_zero <= (r11_v1f == 32'sd0);
            r12_rr   <= w_hr * w_hr;
            r12_v3   <= r11_v3;
            r12_temp <= r11_temp;
            r13_m    <= (r12_rr >>> 7) * c_h1;
            r13_v3   <= r12_v3;
            r13_num  <= r12_num;
            r13_den  <= r12_den;
            r13_half <= r12_half;
            r13_zero <= r12_zero;
            r13_temp <= r12_temp;
            // Humidity limits: the low limit passes through undivided.
            r14_hbyp <= (w_h <= c_hlo);
            if (w_h <= c_hlo) begin
                r14_hsel <= c_hlo;
            end else if (w_h >= c_hhi) begin
                r14_hsel <= c_hhi;
            end else begin
                r14_hsel <= w_h;
            end
            r14_num  <= r13_num;
            r14_den  <= r13_den;
            r14_half <= r13_half;
            r14_zero <= r13_zero;
            r14_temp <= r13_temp;
            // Division by 1000 through the reciprocal.
            r15_hprod <= 61'(r14_hsel) * 61'(HUM_DIV_MAGIC);
            r15_hsel  <= r14_hsel;
            r15_hbyp  <= r14_hbyp;
            r15_num   <= r14_num;
            r15_den   <= r14_den;
            r15_half  <= r14_half;
            r15_zero  <= r14_zero;
            r15_temp  <= r14_temp;
            r16_hum   <= r15_hbyp ? r15_hsel : 32'(r15_hprod >> HUM_DIV_SHIFT);
            r16_num   <= r15_num;
            r16_den   <= r15_den;
            r16_half  <= r15_half;
            r16_zero  <= r15_zero;
            r16_temp  <= r15_temp;
        end
    end

    // ------------------------------------------------------------------
    // Pressure divider with the other results carried alongside.
    // ------------------------------------------------------------------
    logic [31:0] w_quot;
    t_side       r_side [DIV_STEPS];
    t_side       w_side_in;

    assign w_side_in = '{temp: r16_temp, hum: r16_hum, half: r16_half, zero: r16_zero};

    tphc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_vld[PRE_STAGES-1]),
        .i_num   (r16_num),
        .i_den   (r16_den),
        .o_valid (w_div_valid),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_side_in;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pressure correction after division.
    // ------------------------------------------------------------------
    t_side              w_side_out, rp1_side, rp2_side, rp3_side;
    logic [31:0]        w_q, w_q3;
    logic [31:0]        rp1_p, rp1_m, rp2_p, rp3_p;
    logic signed [31:0] rp1_m8, rp2_m8, rp2_m9;

    assign w_side_out = r_side[DIV_STEPS-1];
    assign w_q        = w_side_out.half ? {w_quot[30:0], 1'b0} : w_quot;
    assign w_q3       = w_q >> 3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rp1_p    <= w_q;
            rp1_m    <= w_q3 * w_q3;
            rp1_m8   <= $signed({2'b0, w_q[31:2]}) * c_p8;
            rp1_side <= w_side_out;
            rp2_m9   <= c_p9 * $signed({13'b0, rp1_m[31:13]});
            rp2_m8   <= rp1_m8;
            rp2_p    <= rp1_p;
            rp2_side <= rp1_side;
            if (rp2_side.zero) begin
                rp3_p <= '0;
            end else begin
                rp3_p <= rp2_p + 32'(((rp2_m9 >>> 12) + (rp2_m8 >>> 13) + c_p7) >>> 4);
            end
            rp3_side <= rp2_side;
            // Output register with the pressure clamp.
            if (rp3_p <= c_plo) begin
                o_pressure <= c_plo;
            end else if (rp3_p >= c_phi) begin
                o_pressure <= c_phi;
            end else begin
                o_pressure <= rp3_p;
            end
            o_temperature <= $signed(rp3_side.temp);
            o_humidity    <= rp3_side.hum;
        end
    end

endmodule

@@ tb/sv/tb_tph_sensor_compensation_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tph_sensor_compensation_core
// Self-checking testbench of the compensation core. Coefficients and limits
// are written over APB, sample sets are sent through the input handshake, and
// every result transfer is compared field by field with an in-order queue of
// values computed by a 32-bit integer model of the compensation held here.
// ----------------------------------------------------------------------------
module tb_tph_sensor_compensation_core;
    import tphc_pkg::*;

    localparam int PIPE_CYCLES = 60;
    localparam int WATCHDOG    = 20000;

    typedef struct packed {
        logic [15:0] temp;
        logic [31:0] press;
        logic [31:0] hum;
    } t_reading;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [19:0]        i_temp_raw;
    logic [19:0]        i_press_raw;
    logic [15:0]        i_hum_raw;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_temperature;
    logic [31:0]        o_pressure;
    logic [31:0]        o_humidity;

    // Shadow copy of the register file
    logic [63:0] cal_regs [NUM_REGS];
    t_reading    expected_readings [$];
    int          error_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          stall_pct;
    bit          hold_off;

    tph_sensor_compensation_core i_dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Integer model of the compensation
    // ------------------------------------------------------------------
    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sle_chk(logic [31:0] a, logic [31:0] b);
        return ($signed(a) <= $signed(b));
    endfunction

    function automatic t_reading compensate(logic [19:0] traw_in, logic [19:0] praw_in,
                                             logic [15:0] hraw_in);
        logic [31:0] traw, praw, hraw;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6, tlo, thi, plo, phi, hlo, hhi;
        logic [31:0] v1, v2, v3, v4, v5, d, sq, tfine, t, p, h, x, r;
        t_reading    res;
        traw = traw_in;
        praw = praw_in;
        hraw = hraw_in;
        t1 = cal_regs[0][47:32];
        t2 = sx16(cal_regs[0][31:16]);
        t3 = sx16(cal_regs[0][15:0]);
        p1 = cal_regs[1][63:48];
        p2 = sx16(cal_regs[1][47:32]);
        p3 = sx16(cal_regs[1][31:16]);
        p4 = sx16(cal_regs[1][15:0]);
        p5 = sx16(cal_regs[2][63:48]);
        p6 = sx16(cal_regs[2][47:32]);
        p7 = sx16(cal_regs[2][31:16]);
        p8 = sx16(cal_regs[2][15:0]);
        p9 = sx16(cal_regs[3][55:40]);
        h1 = cal_regs[3][39:32];
        h2 = sx16(cal_regs[3][31:16]);
        h3 = cal_regs[3][15:8];
        h6 = {{24{cal_regs[3][7]}}, cal_regs[3][7:0]};
        h4 = sx16(cal_regs[4][31:16]);
        h5 = sx16(cal_regs[4][15:0]);
        tlo = sx16(cal_regs[5][31:16]);
        thi = sx16(cal_regs[5][15:0]);
        plo = cal_regs[6][63:32];
        phi = cal_regs[6][31:0];
        hlo = cal_regs[7][63:32];
        hhi = cal_regs[7][31:0];

        // Temperature and fine-temperature term
        v1 = asr32(((traw >> 3) - (t1 << 1)) * t2, 11);
        d = (traw >> 4) - t1;
        v2 = asr32(asr32(d * d, 12) * t3, 14);
        tfine = v1 + v2;
        t = asr32(tfine * 32'd5 + 32'd128, 8);
        if (sle_chk(t, tlo)) res.temp = tlo[15:0];
        else if (sle_chk(thi, t)) res.temp = thi[15:0];
        else res.temp = t[15:0];

        // Pressure
        v1 = asr32(tfine, 1) - 32'd64000;
        r = asr32(v1, 2);
        sq = r * r;
        v2 = asr32(sq, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = asr32(v2, 2) + (p4 << 16);
        v1 = asr32(asr32(p3 * asr32(sq, 13), 3) + asr32(p2 * v1, 1), 18);
        v1 = asr32((32'd32768 + v1) * p1, 15);
        p = ((32'd1048576 - praw) - asr32(v2, 12)) * 32'd3125;
        if (v1 != 0) begin
            if (p < 32'h8000_0000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            v1 = asr32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = asr32((p >> 2) * p8, 13);
            p = p + asr32(v1 + v2 + p7, 4);
        end else begin
            p = 0;
        end
        if (p <= plo) res.press = plo;
        else if (p >= phi) res.press = phi;
        else res.press = p;

        // Humidity
        x = tfine - 32'd76800;
        v5 = asr32((hraw << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
        v2 = asr32(x * h6, 10);
        v3 = asr32(x * h3, 11);
        v4 = asr32(v2 * (v3 + 32'd32768), 10) + 32'd2097152;
        v2 = asr32(v4 * h2 + 32'd8192, 14);
        v3 = v5 * v2;
        r = asr32(v3, 15);
        v4 = asr32(r * r, 7);
        v5 = v3 - asr32(v4 * h1, 4);
        if (v5[31]) v5 = 0;
        if (v5 > 32'd419430400) v5 = 32'd419430400;
        h = v5 >> 12;
        if (h <= hlo) res.hum = hlo;
        else if (h >= hhi) res.hum = hhi / 32'd1000;
        else res.hum = h / 32'd1000;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    task automatic write_reg(logic [REG_AW-1:0] idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP_COEFFS: cal_regs[idx] = value & 64'hFFFF_FFFF_FFFF;
            REG_MIXED:       cal_regs[idx] = value & 64'h00FF_FFFF_FFFF_FFFF;
            REG_HUM_OFFSET,
            REG_TEMP_LIMITS: cal_regs[idx] = value & 64'hFFFF_FFFF;
            default:         cal_regs[idx] = value;
        endcase
    endtask

    // Sends one sample set, with a random gap before it in idle phases
    task automatic send_sample(logic [19:0] traw, logic [19:0] praw, logic [15:0] hraw);
        while ($urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(posedge i_clk);
        i_in_valid  <= 1'b1;
        i_temp_raw  <= traw;
        i_press_raw <= praw;
        i_hum_raw   <= hraw;
        expected_readings.push_back(compensate(traw, praw, hraw));
        do @(posedge i_clk); while (o_in_stall);
        i_in_valid <= 1'b0;
    endtask

    // Waits until every result has arrived and the pipeline has drained
    task automatic wait_idle();
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        for (int k = 0; k < count; k++)
            send_sample($urandom, $urandom, $urandom);
    endtask

    // Plausible calibration around typical sensor values, with random spread
    task automatic write_typical_cal();
        write_reg(REG_TEMP_COEFFS, {16'd27504 + 16'($urandom_range(2000)),
                                    16'd26435, 16'hFC18});
        write_reg(REG_PRESS_LOW, {16'd36477 + 16'($urandom_range(2000)),
                                  16'hD68E, 16'd3024, 16'd2855});
        write_reg(REG_PRESS_HIGH, {16'd140, 16'hFFF9, 16'd15500, 16'hD4C0});
        write_reg(REG_MIXED, {16'd6000, 8'd75, 16'd362, 8'd0, 8'd30});
        write_reg(REG_HUM_OFFSET, {16'd313, 16'd50});
        write_reg(REG_TEMP_LIMITS, {16'h8000, 16'h7FFF});
        write_reg(REG_PRESS_LIMITS, {32'd0, 32'hFFFF_FFFF});
        write_reg(REG_HUM_LIMITS, {32'd0, 32'hFFFF_FFFF});
    endtask

    task automatic write_random_cal();
        for (int k = 0; k < NUM_REGS; k++)
            write_reg(REG_AW'(k), {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // All-zero registers: zero pressure divisor throughout
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        send_sample(20'h80000, 20'h80000, 16'h8000);
        wait_idle();
    endtask

    task automatic test_directed_fields();
        write_typical_cal();
        send_sample(20'd519888, 20'd415148, 16'd27000);
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        send_sample('0, '1, 16'h8000);
        send_sample('1, '0, 16'h0001);
        send_sample(20'h55555, 20'hAAAAA, 16'h5A5A);
        wait_idle();
        // Narrow limits so the clamps are taken, then crossed limits
        write_reg(REG_TEMP_LIMITS, {16'd2000, 16'd2500});
        write_reg(REG_PRESS_LIMITS, {32'd95000, 32'd105000});
        write_reg(REG_HUM_LIMITS, {32'd40000, 32'd60000});
        for (int k = 0; k < 6; k++)
            send_sample(20'd480000 + 20'(k * 15000), 20'd300000 + 20'(k * 40000),
                        16'(k * 12000));
        wait_idle();
        write_reg(REG_TEMP_LIMITS, {16'h7FFF, 16'h8000});
        write_reg(REG_PRESS_LIMITS, {32'hFFFF_FFFF, 32'd0});
        write_reg(REG_HUM_LIMITS, {32'hFFFF_FFFF, 32'd0});
        send_sample(20'd519888, 20'd415148, 16'd27000);
        send_sample('1, '1, '1);
        wait_idle();
    endtask

    // Extreme coefficient values, including a near-zero divisor
    task automatic test_extreme_coeffs();
        write_reg(REG_TEMP_COEFFS, 64'hFFFF_7FFF_8000);
        write_reg(REG_PRESS_LOW, 64'hFFFF_8000_7FFF_8000);
        write_reg(REG_PRESS_HIGH, 64'h7FFF_8000_7FFF_8000);
        write_reg(REG_MIXED, 56'h7FFF_FF80_00FF_80);
        write_reg(REG_HUM_OFFSET, 32'h8000_7FFF);
        write_reg(REG_TEMP_LIMITS, {16'h8000, 16'h7FFF});
        write_reg(REG_PRESS_LIMITS, {32'd0, 32'hFFFF_FFFF});
        write_reg(REG_HUM_LIMITS, {32'd0, 32'hFFFF_FFFF});
        send_random(4);
        wait_idle();
        write_reg(REG_PRESS_LOW, 64'h0001_0000_0000_0000);
        send_random(4);
        wait_idle();
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int count, bit typical);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        if (typical) write_typical_cal();
        else write_random_cal();
        for (int k = 0; k < count; k++) begin
            if (typical)
                send_sample(20'd400000 + 20'($urandom_range(200000)),
                            20'd200000 + 20'($urandom_range(400000)), $urandom);
            else
                send_sample($urandom, $urandom, $urandom);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            run_phase(0, 0, 150, 1'b1);
            run_phase(59, 0, 60, ph[0]);
            run_phase(0, 59, 60, 1'b1);
            run_phase(14, 14, 120, ph[1]);
        end
    endtask

    // Long hold-off on the output while samples keep coming
    task automatic test_back_pressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_typical_cal();
        hold_off = 1'b1;
        send_random(150);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Output stall generation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_off) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // The hold-off lasts a counted stretch and then releases
    initial begin
        wait (hold_off);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reading exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result transfer temp=%0d press=%0d hum=%0d",
                         $time, o_temperature, o_pressure, o_humidity);
                error_count++;
            end else begin
                exp_r = expected_readings.pop_front();
                if (o_temperature !== exp_r.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $time,
                             $signed(exp_r.temp), o_temperature);
                    error_count++;
                end
                if (o_pressure !== exp_r.press) begin
                    $display("%0t: pressure expected %0d actual %0d", $time,
                             exp_r.press, o_pressure);
                    error_count++;
                end
                if (o_humidity !== exp_r.hum) begin
                    $display("%0t: humidity expected %0d actual %0d", $time,
                             exp_r.hum, o_humidity);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_temp_raw    = '0;
        i_press_raw   = '0;
        i_hum_raw     = '0;
        i_out_stall   = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off      = 1'b0;
        for (int k = 0; k < NUM_REGS; k++) cal_regs[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_fields();
        test_extreme_coeffs();
        test_random_traffic();
        test_back_pressure();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
